### sv/aazc_pkg.sv
// package: types, constants and angle helpers of the arm angle zone classifier
`default_nettype none
package aazc_pkg;

  localparam int unsigned AngleW  = 10;
  localparam int unsigned StatusW = 8;
  localparam int unsigned LocW    = 8;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned DiffW   = 12;

  localparam logic signed [DiffW-1:0] HalfTurn = 12'sd512;
  localparam logic signed [DiffW-1:0] FullTurn = 12'sd1024;
  localparam logic signed [DiffW-1:0] FastStep = 12'sd30;
  localparam logic signed [DiffW-1:0] DirHyst  = 12'sd8;

  localparam logic [LocW-1:0] LocDir   = 8'h80;
  localparam logic [LocW-1:0] LocNeg   = 8'h40;
  localparam logic [LocW-1:0] LocZone3 = 8'h08;
  localparam logic [LocW-1:0] LocZone2 = 8'h04;
  localparam logic [LocW-1:0] LocZone1 = 8'h02;
  localparam logic [LocW-1:0] LocZone0 = 8'h01;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REST_A     = 4'd0,
    REG_REST_B     = 4'd1,
    REG_REST_C     = 4'd2,
    REG_REST_TOL   = 4'd3,
    REG_PASS_ANGLE = 4'd4,
    REG_ZONE_ONE   = 4'd5,
    REG_ZONE_TWO   = 4'd6,
    REG_ZONE_THREE = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [AngleW-1:0] rest_a;
    logic [AngleW-1:0] rest_b;
    logic [AngleW-1:0] rest_c;
    logic [AngleW-1:0] rest_tol;
    logic [AngleW-1:0] pass_angle;
    logic [AngleW-1:0] zone_one;
    logic [AngleW-1:0] zone_two;
    logic [AngleW-1:0] zone_three;
  } cfg_t;

  typedef struct packed {
    logic               dir;
    logic [AngleW-1:0]  ref_rest;
    logic [AngleW-1:0]  dir_ref;
    logic [AngleW-1:0]  prev_angle;
    logic               pass_rep;
    logic [StatusW-1:0] status_latch;
  } state_t;

  // signed difference to - from, folded into -512..+512
  function automatic logic signed [DiffW-1:0] wrap_diff(input logic [AngleW-1:0] from,
                                                         input logic [AngleW-1:0] to);
    logic signed [DiffW-1:0] raw;
    raw = $signed({2'b00, to}) - $signed({2'b00, from});
    if (raw > HalfTurn) begin
      return raw - FullTurn;
    end else if (raw < -HalfTurn) begin
      return raw + FullTurn;
    end
    return raw;
  endfunction

  function automatic logic is_within(input logic signed [DiffW-1:0] d,
                                     input logic [AngleW-1:0] lim);
    logic signed [DiffW-1:0] l;
    l = $signed({2'b00, lim});
    return (d < l) && (d > -l);
  endfunction

  function automatic logic is_beyond(input logic signed [DiffW-1:0] d,
                                     input logic [AngleW-1:0] lim);
    logic signed [DiffW-1:0] l;
    l = $signed({2'b00, lim});
    return (d > l) || (d < -l);
  endfunction

endpackage
`default_nettype wire

### sv/aazc_if.sv
// channel interfaces: angle samples, results and configuration writes
`default_nettype none
interface aazc_in_if;
  logic                         valid;
  logic                         ready;
  logic [aazc_pkg::AngleW-1:0]  angle;
  logic [aazc_pkg::StatusW-1:0] status_byte;
  modport source (output valid, output angle, output status_byte, input ready);
  modport sink (input valid, input angle, input status_byte, output ready);
endinterface

interface aazc_out_if;
  logic                         valid;
  logic                         ready;
  logic [aazc_pkg::LocW-1:0]    location_code;
  logic                         fact_pass;
  logic [aazc_pkg::StatusW-1:0] captured_status;
  modport source (output valid, output location_code, output fact_pass,
                  output captured_status, input ready);
  modport sink (input valid, input location_code, input fact_pass,
                input captured_status, output ready);
endinterface

interface aazc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [aazc_pkg::CfgIdxW-1:0] index;
  logic [aazc_pkg::AngleW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### sv/aazc_regs.sv
// configuration register file
`default_nettype none
module aazc_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_en_i,
  input  wire logic [aazc_pkg::CfgIdxW-1:0] wr_idx_i,
  input  wire logic [aazc_pkg::AngleW-1:0]  wr_data_i,
  output aazc_pkg::cfg_t                    cfg_o
);
  import aazc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_reg_e'(wr_idx_i))
        REG_REST_A:     cfg_d.rest_a     = wr_data_i;
        REG_REST_B:     cfg_d.rest_b     = wr_data_i;
        REG_REST_C:     cfg_d.rest_c     = wr_data_i;
        REG_REST_TOL:   cfg_d.rest_tol   = wr_data_i;
        REG_PASS_ANGLE: cfg_d.pass_angle = wr_data_i;
        REG_ZONE_ONE:   cfg_d.zone_one   = wr_data_i;
        REG_ZONE_TWO:   cfg_d.zone_two   = wr_data_i;
        REG_ZONE_THREE: cfg_d.zone_three = wr_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rest_a     <= 10'd0;
      cfg_q.rest_b     <= 10'd0;
      cfg_q.rest_c     <= 10'd0;
      cfg_q.rest_tol   <= 10'd8;
      cfg_q.pass_angle <= 10'd200;
      cfg_q.zone_one   <= 10'd30;
      cfg_q.zone_two   <= 10'd100;
      cfg_q.zone_three <= 10'd200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### sv/aazc_step.sv
// per-sample classification and next-state logic
`default_nettype none
module aazc_step (
  input  wire aazc_pkg::cfg_t               cfg_i,
  input  wire aazc_pkg::state_t             state_i,
  input  wire logic [aazc_pkg::AngleW-1:0]  angle_i,
  input  wire logic [aazc_pkg::StatusW-1:0] status_i,
  output aazc_pkg::state_t                  state_o,
  output logic [aazc_pkg::LocW-1:0]         loc_o,
  output logic                              pass_o,
  output logic [aazc_pkg::StatusW-1:0]      capt_o
);
  import aazc_pkg::*;

  logic                    in_a, in_b, in_c;
  logic signed [DiffW-1:0] d_step, d_dir, d_ref;

  always_comb begin
    in_a   = is_within(wrap_diff(cfg_i.rest_a, angle_i), cfg_i.rest_tol);
    in_b   = is_within(wrap_diff(cfg_i.rest_b, angle_i), cfg_i.rest_tol);
    in_c   = is_within(wrap_diff(cfg_i.rest_c, angle_i), cfg_i.rest_tol);
    d_step = wrap_diff(state_i.prev_angle, angle_i);
    d_dir  = wrap_diff(state_i.dir_ref, angle_i);
    d_ref  = wrap_diff(state_i.ref_rest, angle_i);

    state_o = state_i;
    pass_o  = 1'b0;
    loc_o   = state_i.dir ? LocDir : '0;

    if (in_a || in_b || in_c) begin
      // rest window: only the reference and the pass flag change
      state_o.ref_rest = in_a ? cfg_i.rest_a : (in_b ? cfg_i.rest_b : cfg_i.rest_c);
      state_o.pass_rep = 1'b0;
    end else begin
      if (d_step > FastStep) begin
        state_o.status_latch = status_i;
      end
      state_o.prev_angle = angle_i;

      if (d_dir < -DirHyst) begin
        state_o.dir     = 1'b1;
        state_o.dir_ref = angle_i;
      end
      if (d_dir > DirHyst) begin
        state_o.dir     = 1'b0;
        state_o.dir_ref = angle_i;
      end
      loc_o = state_o.dir ? LocDir : '0;

      // sign bit marks the negative side
      if (d_ref[DiffW-1]) begin
        loc_o = loc_o | LocNeg;
      end
      if (is_beyond(d_ref, cfg_i.pass_angle) && !state_i.pass_rep) begin
        pass_o           = 1'b1;
        state_o.pass_rep = 1'b1;
      end

      if (is_beyond(d_ref, cfg_i.zone_three)) begin
        loc_o = loc_o | LocZone3;
      end else if (is_beyond(d_ref, cfg_i.zone_two)) begin
        loc_o = loc_o | LocZone2;
      end else if (is_beyond(d_ref, cfg_i.zone_one)) begin
        loc_o = loc_o | LocZone1;
      end else if (is_beyond(d_ref, cfg_i.rest_tol)) begin
        loc_o = loc_o | LocZone0;
      end else begin
        // inner dead band clears the whole location
        loc_o       = '0;
        state_o.dir = 1'b0;
      end
    end

    capt_o = state_o.status_latch;
  end

endmodule
`default_nettype wire

### sv/arm_angle_zone_classifier_core.sv
// top level of the arm angle zone classifier
// Takes one angle sample per cycle while the output side takes results, and
// returns one result per sample, in order. A sample is captured in an input
// register, classified and written to the output register, which holds the
// result until it is taken. The tracking state (rest reference, direction,
// previous angle, pass flag, status latch) is updated together with the output
// register, so consecutive samples stream at one per clock while the output side
// takes results. The output register decouples the two sides: while a result
// waits, one more sample can still be taken into the input register before the
// input stalls. Configuration registers are written through a separate channel
// that is always ready; write them only while no sample is in flight.
`default_nettype none
module arm_angle_zone_classifier_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aazc_in_if.sink   in_i,
  aazc_out_if.source out_o,
  aazc_cfg_if.sink  cfg_i
);
  import aazc_pkg::*;

  cfg_t   cfg;
  state_t state_q, state_d;

  logic               in_vld_q;
  logic [AngleW-1:0]  angle_q;
  logic [StatusW-1:0] status_q;

  logic               out_vld_q;
  logic [LocW-1:0]    loc_q, loc_d;
  logic               pass_q, pass_d;
  logic [StatusW-1:0] capt_q, capt_d;

  logic advance, process, in_ready;

  assign cfg_i.ready = 1'b1;

  aazc_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cfg_i.valid),
    .wr_idx_i (cfg_i.index),
    .wr_data_i(cfg_i.data),
    .cfg_o    (cfg)
  );

  aazc_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .angle_i (angle_q),
    .status_i(status_q),
    .state_o (state_d),
    .loc_o   (loc_d),
    .pass_o  (pass_d),
    .capt_o  (capt_d)
  );

  assign advance  = !out_vld_q || out_o.ready;
  assign process  = in_vld_q && advance;
  assign in_ready = !in_vld_q || advance;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (in_ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (process) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      angle_q  <= in_i.angle;
      status_q <= in_i.status_byte;
    end
    if (process) begin
      loc_q  <= loc_d;
      pass_q <= pass_d;
      capt_q <= capt_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.location_code   = loc_q;
  assign out_o.fact_pass       = pass_q;
  assign out_o.captured_status = capt_q;

`ifndef NO_ASSERTIONS
  // at most one zone bit, and the unused middle bits stay clear
  a_zone_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ($onehot0(loc_q[3:0]) && loc_q[5:4] == 2'b00))
    else $error("location code malformed");

  // a pass pulse leaves the pass flag set
  a_pass_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && pass_d) |=> state_q.pass_rep)
    else $error("pass flag not set after pulse");

  // input stalls only when both stages hold transactions and the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (in_vld_q && out_vld_q && !out_o.ready))
    else $error("input stalled without cause");
`endif

endmodule
`default_nettype wire

### sim/tb.sv
// testbench: streams arm angle samples through the zone classifier and checks every result
module tb;
  import aazc_pkg::*;

  localparam int HalfTurnCounts = 512;
  localparam int FullTurnCounts = 1024;
  localparam int FastStepCounts = 30;
  localparam int DirHystCounts  = 8;
  localparam int HoldOffCycles  = 150;
  localparam int PhaseItems     = 150;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [AngleW-1:0]  angle;
    logic [StatusW-1:0] status;
  } arm_sample_t;

  typedef struct packed {
    logic [LocW-1:0]    loc;
    logic               fact_pass;
    logic [StatusW-1:0] status;
  } zone_result_t;

  logic clk;
  logic rst_n;

  aazc_in_if  in_if ();
  aazc_out_if out_if ();
  aazc_cfg_if cfg_if ();

  arm_angle_zone_classifier_core i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copy and tracking state of the predictor
  logic [AngleW-1:0]  cfg_regs [8];
  logic               trk_dir;
  logic [AngleW-1:0]  trk_rest;
  logic [AngleW-1:0]  trk_dir_ref;
  logic [AngleW-1:0]  trk_prev;
  logic               trk_pass_seen;
  logic [StatusW-1:0] trk_status;

  arm_sample_t  angle_q [$];
  zone_result_t pending_results [$];
  arm_sample_t  next_sample;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          pressure_req;
  bit          hold_off;
  int unsigned mismatch_count;
  int unsigned samples_taken;
  int unsigned results_checked;
  int unsigned pulses_seen;
  int unsigned settings_used;

  // to - from, folded into -512..+512
  function automatic int fold_diff(logic [AngleW-1:0] from_a, logic [AngleW-1:0] to_a);
    int d;
    d = int'(to_a) - int'(from_a);
    if (d > HalfTurnCounts) begin
      d -= FullTurnCounts;
    end else if (d < -HalfTurnCounts) begin
      d += FullTurnCounts;
    end
    return d;
  endfunction

  function automatic bit strictly_near(int d, logic [AngleW-1:0] lim);
    return (d < int'(lim)) && (d > -int'(lim));
  endfunction

  function automatic bit clearly_past(int d, logic [AngleW-1:0] lim);
    return (d > int'(lim)) || (d < -int'(lim));
  endfunction

  function automatic zone_result_t classify_sample(logic [AngleW-1:0] angle,
                                                   logic [StatusW-1:0] status);
    zone_result_t r;
    logic [AngleW-1:0] rest;
    int d;
    r.loc = trk_dir ? LocDir : '0;
    r.fact_pass = 1'b0;
    // rest window: priority a, b, c; only the reference and pass flag change
    for (int i = 0; i < 3; i++) begin
      rest = cfg_regs[i];
      if (strictly_near(fold_diff(rest, angle), cfg_regs[REG_REST_TOL])) begin
        trk_rest = rest;
        trk_pass_seen = 1'b0;
        r.status = trk_status;
        return r;
      end
    end
    if (fold_diff(trk_prev, angle) > FastStepCounts) begin
      trk_status = status;
    end
    trk_prev = angle;
    d = fold_diff(trk_dir_ref, angle);
    if (d < -DirHystCounts) begin
      trk_dir = 1'b1;
      trk_dir_ref = angle;
    end
    if (d > DirHystCounts) begin
      trk_dir = 1'b0;
      trk_dir_ref = angle;
    end
    r.loc = trk_dir ? LocDir : '0;
    d = fold_diff(trk_rest, angle);
    if (d < 0) begin
      r.loc |= LocNeg;
    end
    if (clearly_past(d, cfg_regs[REG_PASS_ANGLE]) && !trk_pass_seen) begin
      r.fact_pass = 1'b1;
      trk_pass_seen = 1'b1;
    end
    if (clearly_past(d, cfg_regs[REG_ZONE_THREE])) begin
      r.loc |= LocZone3;
    end else if (clearly_past(d, cfg_regs[REG_ZONE_TWO])) begin
      r.loc |= LocZone2;
    end else if (clearly_past(d, cfg_regs[REG_ZONE_ONE])) begin
      r.loc |= LocZone1;
    end else if (clearly_past(d, cfg_regs[REG_REST_TOL])) begin
      r.loc |= LocZone0;
    end else begin
      // inner dead band clears the whole location
      r.loc = '0;
      trk_dir = 1'b0;
    end
    r.status = trk_status;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_result();
    zone_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending, location_code", out_if.location_code, 0);
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (out_if.fact_pass) begin
      pulses_seen++;
    end
    if (out_if.location_code !== want.loc) begin
      report_mismatch("location_code", out_if.location_code, want.loc);
    end
    if (out_if.fact_pass !== want.fact_pass) begin
      report_mismatch("fact_pass", out_if.fact_pass, want.fact_pass);
    end
    if (out_if.captured_status !== want.status) begin
      report_mismatch("captured_status", out_if.captured_status, want.status);
    end
  endtask

  // sample driver: holds a transaction until taken, then maybe idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        pending_results.push_back(classify_sample(in_if.angle, in_if.status_byte));
        samples_taken++;
      end
      if (angle_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_sample = angle_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.angle <= next_sample.angle;
        in_if.status_byte <= next_sample.status;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        check_result();
      end
      out_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (pressure_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results pending", pending_results.size());
    $display("status: fail");
    $finish;
  end

  task automatic push_sample(logic [AngleW-1:0] angle, logic [StatusW-1:0] status);
    angle_q.push_back('{angle: angle, status: status});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (angle_q.size() != 0 || in_if.valid || pending_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [AngleW-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_regs[idx] = value;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_all(int a, int b, int c, int tol, int pa, int z1, int z2, int z3);
    write_reg(REG_REST_A, 10'(a));
    write_reg(REG_REST_B, 10'(b));
    write_reg(REG_REST_C, 10'(c));
    write_reg(REG_REST_TOL, 10'(tol));
    write_reg(REG_PASS_ANGLE, 10'(pa));
    write_reg(REG_ZONE_ONE, 10'(z1));
    write_reg(REG_ZONE_TWO, 10'(z2));
    write_reg(REG_ZONE_THREE, 10'(z3));
    settings_used++;
  endtask

  task automatic set_ordered_random();
    int tol, z1, z2;
    tol = $urandom_range(1, 30);
    z1 = tol + $urandom_range(0, 40);
    z2 = z1 + $urandom_range(0, 80);
    set_all($urandom_range(1023), $urandom_range(1023), $urandom_range(1023), tol,
            $urandom_range(512), z1, z2, z2 + $urandom_range(0, 200));
  endtask

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 53;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 53;
      end
      default: begin
        send_idle_pct = 6;
        recv_stall_pct = 6;
      end
    endcase
  endtask

  // arm swings out from a rest angle and back, with some noise samples
  task automatic queue_swings(int unsigned count);
    int unsigned pushed;
    int offset, reach, sgn, stride_max, center;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(4) == 0) begin
        push_sample(10'($urandom_range(1023)), 8'($urandom_range(255)));
        pushed++;
      end else begin
        center = cfg_regs[$urandom_range(2)];
        reach = $urandom_range(600);
        sgn = $urandom_range(1) ? 1 : -1;
        stride_max = $urandom_range(2, 45);
        offset = 0;
        while (offset < reach && pushed < count) begin
          offset += $urandom_range(1, stride_max);
          push_sample(10'(center + sgn * offset), 8'($urandom_range(255)));
          pushed++;
        end
        while (offset > 0 && pushed < count) begin
          offset -= $urandom_range(1, stride_max);
          if (offset < 0) begin
            offset = 0;
          end
          push_sample(10'(center + sgn * offset), 8'($urandom_range(255)));
          pushed++;
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.angle = '0;
    in_if.status_byte = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_REST_A;
    cfg_if.data = '0;
    cfg_regs = '{10'd0, 10'd0, 10'd0, 10'd8, 10'd200, 10'd30, 10'd100, 10'd200};
    trk_dir = 1'b0;
    trk_rest = '0;
    trk_dir_ref = '0;
    trk_prev = '0;
    trk_pass_seen = 1'b0;
    trk_status = '0;
    set_idle(IDLE_NONE);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: rest window, dead band edges, fast steps, passage, wrap
    push_sample(10'd0, 8'h00);
    push_sample(10'd8, 8'h11);
    push_sample(10'd1016, 8'h22);
    push_sample(10'd9, 8'h33);
    push_sample(10'd40, 8'hff);
    push_sample(10'd70, 8'h55);
    push_sample(10'd101, 8'hAA);
    push_sample(10'd201, 8'h01);
    push_sample(10'd300, 8'h80);
    push_sample(10'd512, 8'h7f);
    push_sample(10'd513, 8'h02);
    push_sample(10'd700, 8'h04);
    push_sample(10'd650, 8'h08);
    push_sample(10'd3, 8'h10);
    push_sample(10'd250, 8'h20);
    push_sample(10'd1023, 8'h40);
    wait_drained();
    // reference at a half turn: minus half turn stays negative
    set_all(512, 256, 768, 8, 200, 30, 100, 200);
    push_sample(10'd512, 8'h00);
    push_sample(10'd0, 8'hff);
    push_sample(10'd768, 8'h5a);
    wait_drained();
    // all limits zero
    set_all(0, 0, 0, 0, 0, 0, 0, 0);
    push_sample(10'd0, 8'h00);
    push_sample(10'd1, 8'hff);
    push_sample(10'd1023, 8'h3c);
    wait_drained();
    // tolerance above a half turn puts every sample at rest
    set_all(100, 200, 300, 600, 200, 30, 100, 200);
    push_sample(10'd812, 8'hc3);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      set_idle(idle_mode_e'(p % 4));
      case (p)
        0: set_all($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                   8, 200, 30, 100, 200);
        1: set_all(0, 0, 0, 0, 0, 0, 0, 0);
        2: set_all(1023, 1023, 1023, 512, 512, 512, 512, 512);
        4: set_all($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(1023), $urandom_range(1023));
        5: set_all($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(513, 1023), 200, 30, 100, 200);
        7: begin
          // overlapping rest windows check the a, b, c priority
          int r;
          r = $urandom_range(1023);
          set_all(r, r + 5, r + 10, 12, $urandom_range(512), 20, 60, 140);
        end
        default: set_ordered_random();
      endcase
      if (p == 6) begin
        send_idle_pct = 0;
        pressure_req = 1'b1;
        queue_swings(60);
        wait_drained();
      end
      queue_swings(p == 5 ? 40 : PhaseItems);
      wait_drained();
    end

    $display("checked %0d results from %0d samples over %0d register settings",
             results_checked, samples_taken, settings_used);
    $display("%0d passage pulses seen, long output hold-off of %0d cycles included",
             pulses_seen, HoldOffCycles);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
sv/aazc_pkg.sv
sv/aazc_if.sv
sv/aazc_regs.sv
sv/aazc_step.sv
sv/arm_angle_zone_classifier_core.sv
sim/tb.sv
